/* sv/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 stream encoder
// Holds the queue entry layout, the result layout and the alphabet lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64e_pkg;

  // Number of entries in the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Register index of the capacity register on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset.
  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // ASCII codes used by the alphabet.
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2B;
  localparam logic [7:0] ASCII_SLASH   = 8'h2F;
  localparam logic [7:0] PAD_CHAR      = 8'h3D;

  // Number of pending bits held by the front between bytes.
  typedef enum logic [2:0] {
    LC_ZERO = 3'b001,
    LC_TWO  = 3'b010,
    LC_FOUR = 3'b100
  } lc_e;

  // One queue entry: up to two 6-bit groups to send, then optional padding
  // and the closing status when eom is set.
  typedef struct packed {
    logic [1:0][5:0] six;
    logic [1:0]      nchar;
    logic            eom;
  } job_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0]  out_char;
    logic        is_char;
    logic        last_of_run;
    logic        status;
    logic [15:0] char_count;
  } res_t;

  // Standard base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      return 8'(ASCII_UPPER_A + wide);
    end else if (idx < 6'd52) begin
      return 8'(ASCII_LOWER_A + wide - 8'd26);
    end else if (idx < 6'd62) begin
      return 8'(ASCII_ZERO + wide - 8'd52);
    end else if (idx == 6'd62) begin
      return ASCII_PLUS;
    end else begin
      return ASCII_SLASH;
    end
  endfunction

endpackage

/* sv/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front: bit buffer and request classifier
// Appends each byte to the pending bits, cuts out complete 6-bit groups and
// the flush group, and hands them to the queue as at most one entry per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_valid_i,
  input  logic              end_of_message_i,
  input  logic              full_i,
  output logic              push_o,
  output b64e_pkg::job_t    job_o
);

  b64e_pkg::lc_e lc_q, lc_d, lc_mid;
  logic [3:0]    bits_q, bits_d, bits_mid;
  logic          accept;

  assign accept = in_valid_i && !full_i;
  assign push_o = accept && (byte_valid_i || end_of_message_i);

  always_comb begin
    job_o     = '0;
    lc_mid    = lc_q;
    bits_mid  = bits_q;
    if (byte_valid_i) begin
      unique case (lc_q)
        b64e_pkg::LC_ZERO: begin
          job_o.six[0] = data_byte_i[7:2];
          job_o.nchar  = 2'd1;
          bits_mid     = {2'b00, data_byte_i[1:0]};
          lc_mid       = b64e_pkg::LC_TWO;
        end
        b64e_pkg::LC_TWO: begin
          job_o.six[0] = {bits_q[1:0], data_byte_i[7:4]};
          job_o.nchar  = 2'd1;
          bits_mid     = data_byte_i[3:0];
          lc_mid       = b64e_pkg::LC_FOUR;
        end
        b64e_pkg::LC_FOUR: begin
          job_o.six[0] = {bits_q, data_byte_i[7:6]};
          job_o.six[1] = data_byte_i[5:0];
          job_o.nchar  = 2'd2;
          bits_mid     = '0;
          lc_mid       = b64e_pkg::LC_ZERO;
        end
        default: begin
          bits_mid = '0;
          lc_mid   = b64e_pkg::LC_ZERO;
        end
      endcase
    end

    lc_d   = lc_mid;
    bits_d = bits_mid;
    if (end_of_message_i) begin
      // The flush group is left-aligned and zero-filled.
      unique case (lc_mid)
        b64e_pkg::LC_TWO: begin
          job_o.six[job_o.nchar[0]] = {bits_mid[1:0], 4'b0000};
          job_o.nchar               = 2'(job_o.nchar + 2'd1);
        end
        b64e_pkg::LC_FOUR: begin
          job_o.six[job_o.nchar[0]] = {bits_mid, 2'b00};
          job_o.nchar               = 2'(job_o.nchar + 2'd1);
        end
        default: begin
        end
      endcase
      job_o.eom = 1'b1;
      lc_d      = b64e_pkg::LC_ZERO;
      bits_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q   <= b64e_pkg::LC_ZERO;
      bits_q <= '0;
    end else if (accept) begin
      lc_q   <= lc_d;
      bits_q <= bits_d;
    end
  end

endmodule

/* sv/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue: short queue between front and back
// A small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output b64e_pkg::job_t head_o
);

  localparam int unsigned Depth = b64e_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  b64e_pkg::job_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + PtrW'(1));
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + PtrW'(1));
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + CntW'(1));
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* sv/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back: character sequencer and output register
// Works through one queue entry a step per cycle while the output is not stalled: groups, padding, status.
// Keeps the character count and the sticky overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  b64e_pkg::job_t job_i,
  input  logic [15:0]    capacity_i,
  input  logic           out_stall_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output b64e_pkg::res_t res_o
);

  localparam int unsigned ExtW = COUNT_WIDTH + 16;

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_next;
  logic                   ovf_q, ovf_d;
  logic [1:0]             idx_q, idx_d, idx_inc;
  logic                   out_valid_q, out_valid_d;
  b64e_pkg::res_t         res_q, res_d;

  logic            can_load, step, kind_char, kind_pad;
  logic            suppress, next_suppress, last_char;
  logic [ExtW-1:0] cap_ext, cnt_ext, next_ext;
  logic [7:0]      ch;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign step       = job_valid_i && can_load;
  assign kind_char  = (idx_q < job_i.nchar);
  assign kind_pad   = !kind_char && (count_q[1:0] != 2'b00);
  assign count_next = COUNT_WIDTH'(count_q + COUNT_WIDTH'(1));
  assign idx_inc    = 2'(idx_q + 2'd1);

  assign cap_ext       = {{COUNT_WIDTH{1'b0}}, capacity_i};
  assign cnt_ext       = {16'b0, count_q};
  assign next_ext      = {16'b0, count_next};
  assign suppress      = (cnt_ext >= cap_ext);
  assign next_suppress = (next_ext >= cap_ext);

  // Without end of message the entry ends on its last group; a later group
  // that will be dropped moves the end-of-run mark forward.
  assign last_char = !job_i.eom && ((idx_inc == job_i.nchar) || next_suppress);
  assign ch        = kind_char ? b64e_pkg::b64_char(job_i.six[idx_q[0]])
                               : b64e_pkg::PAD_CHAR;

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (step) begin
      priority if (kind_char || kind_pad) begin
        count_d = count_next;
        if (suppress) begin
          ovf_d = 1'b1;
        end else begin
          res_d.out_char    = ch;
          res_d.is_char     = 1'b1;
          res_d.last_of_run = last_char;
          res_d.status      = 1'b0;
          res_d.char_count  = next_ext[15:0];
          out_valid_d       = 1'b1;
        end
        if (kind_char) begin
          idx_d = idx_inc;
          if (!job_i.eom && (idx_inc == job_i.nchar)) begin
            pop_o = 1'b1;
            idx_d = '0;
          end
        end
      end else begin
        res_d.out_char    = '0;
        res_d.is_char     = 1'b0;
        res_d.last_of_run = 1'b1;
        res_d.status      = ovf_q || suppress;
        res_d.char_count  = cnt_ext[15:0];
        out_valid_d       = 1'b1;
        pop_o             = 1'b1;
        count_d           = '0;
        ovf_d             = 1'b0;
        idx_d             = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* sv/base64_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top: streaming base64 encoder with padded output
// A request's groups are held in the queue and then pass the output register.
// Throughput: at most one result per cycle while the output is not stalled; a
// byte yields one or two characters, an end-of-message request its flush group,
// pads and status. The front takes a request per cycle while the two-entry queue has room.
// Reset (rst_ni low, asynchronous): stream state, queue and output clear;
// capacity returns to 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_stream_encoder_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,

  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        is_char_o,
  output logic        last_of_run_o,
  output logic        status_o,
  output logic [15:0] char_count_o,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The only register is the output capacity, at byte address 0. It counts
  // one slot for a terminator, so a message whose final length reaches it is
  // reported as truncated.
  logic [15:0] capacity_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == b64e_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == b64e_pkg::REG_CAPACITY) ? {16'b0, capacity_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= b64e_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity_q <= pwdata[15:0];
    end
  end

  // Front: keeps the 0, 2 or 4 pending bits and turns each request into one
  // queue entry holding the 6-bit groups to send and the end-of-message mark.
  // Requests that carry neither a byte nor an end mark are taken and dropped.
  logic           push;
  logic           full;
  b64e_pkg::job_t job_in;

  assign in_stall_o = full;

  b64e_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .byte_valid_i    (byte_valid_i),
    .end_of_message_i(end_of_message_i),
    .full_i          (full),
    .push_o          (push),
    .job_o           (job_in)
  );

  // Queue: decouples the front from the back so that a stalled output does
  // not block the next request until the queue fills.
  logic           pop;
  logic           head_valid;
  b64e_pkg::job_t head;

  b64e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .head_o (head)
  );

  // Back: one step per cycle through the head entry while the output is not
  // stalled. Characters past the capacity are counted but not sent, and set a
  // sticky overflow flag. On end of message it pads with '=' to a multiple of four and sends status.
  b64e_pkg::res_t res;

  b64e_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_i      (head),
    .capacity_i (capacity_q),
    .out_stall_i(out_stall_i),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .res_o      (res)
  );

  assign out_char_o    = res.out_char;
  assign is_char_o     = res.is_char;
  assign last_of_run_o = res.last_of_run;
  assign status_o      = res.status;
  assign char_count_o  = res.char_count;

endmodule

/* sv/b64e_checker.sv */
// ----------------------------------------------------------------------------
// b64e_checker: port-level checks of the base64 stream encoder
// Watches the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_char_o,
  input logic        is_char_o,
  input logic        last_of_run_o,
  input logic        status_o,
  input logic [15:0] char_count_o,
  input logic        pready
);

  // A stalled result stays and does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(is_char_o) && $stable(last_of_run_o) && $stable(status_o) &&
      $stable(char_count_o))
    else $error("stalled result changed");

  // The closing result ends its run and carries no character.
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_char_o |-> last_of_run_o && (out_char_o == 8'h00))
    else $error("malformed closing result");

  // Character results never carry a truncation status.
  a_char_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_char_o |-> !status_o)
    else $error("character result with status set");

  // A message closed without truncation is padded to a multiple of four.
  a_ok_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_char_o && !status_o |-> (char_count_o[1:0] == 2'b00))
    else $error("final length not a multiple of four");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_char_o   (out_char_o),
  .is_char_o    (is_char_o),
  .last_of_run_o(last_of_run_o),
  .status_o     (status_o),
  .char_count_o (char_count_o),
  .pready       (pready)
);
